@@ rtl/msb_pkg.sv @@
// shared constants, types and helpers for the multi-stack shared buffer
`timescale 1ns / 1ps
package msb_pkg;

  // sizing
  localparam int STACKS = 4;
  localparam int SLOTS  = 16;
  localparam int DATA_W = 32;
  localparam int SID_W  = 2;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTR_W  = $clog2(SLOTS + 1);
  localparam int STK_W  = (STACKS > 1) ? $clog2(STACKS) : 1;

  // pointer value that marks the end of a list
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);

  // word returned by a pop of an empty stack
  localparam logic [DATA_W-1:0] UNDERFLOW_WORD = 32'h7fff_ffff;

  // request kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // write request into the link store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [PTR_W-1:0] ptr;
  } link_wr_t;

  // any pointer past the last slot counts as end of list
  function automatic logic is_null(input logic [PTR_W-1:0] p);
    is_null = (p >= NULL_PTR);
  endfunction

endpackage

@@ rtl/msb_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps
module msb_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/msb_link_store.sv @@
// link store: per-slot next pointers, each slot links to the next one until written
`timescale 1ns / 1ps
module msb_link_store
  import msb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  link_wr_t         wr,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output logic [PTR_W-1:0] rdata
);

  logic [PTR_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0] written;

  // write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.idx] <= wr.ptr;
    end
  end

  // per-slot written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.we) begin
      written[wr.idx] <= 1'b1;
    end
  end

  // read port; an unwritten slot reads as its reset link (slot plus one)
  always_ff @(posedge clk) begin
    if (re) begin
      if (written[raddr]) begin
        rdata <= mem[raddr];
      end else begin
        rdata <= PTR_W'(raddr) + PTR_W'(1);
      end
    end
  end

endmodule

@@ rtl/multi_stack_shared_buffer_unit.sv @@
// top level: several lifo stacks sharing one slot store through a free list
`timescale 1ns / 1ps
// Each request is handled in an accept step and an update step: in the
// accept step the addressed slot (free list head for a push, stack top for
// a pop) is read from the link and data memories, in the update step the
// links, stack top and free head are updated and written back and the
// result is loaded into the output register. The dependent memory read
// followed by the write-back means a new request is not taken until the
// update of the previous one is done. A new request is taken while an
// earlier result still waits in the output register; the update of the
// next request holds until that result is taken. The link memory needs no
// clearing pass after reset: the block is ready in the first cycle after reset is released.
module multi_stack_shared_buffer_unit
  import msb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              kind,
  input  logic [SID_W-1:0]  stack_id,
  input  logic [DATA_W-1:0] value,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [DATA_W-1:0] pop_data,
  output logic [1:0]        status,
  output logic              store_full,
  output logic              stack_empty
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t           state;
  logic [PTR_W-1:0] stack_top [STACKS];
  logic [PTR_W-1:0] free_head;

  // latched request
  logic              r_kind;
  logic              r_sid_ok;
  logic [STK_W-1:0]  r_sidx;
  logic [DATA_W-1:0] r_value;
  logic [PTR_W-1:0]  r_slot;

  // request decode at accept
  logic              accept;
  logic              sid_ok;
  logic [STK_W-1:0]  sidx;
  logic [PTR_W-1:0]  top_in;
  logic [PTR_W-1:0]  slot_in;

  // update stage
  logic              exec_go;
  logic [PTR_W-1:0]  link_q;
  logic [DATA_W-1:0] data_q;
  logic [PTR_W-1:0]  top_cur;
  logic [PTR_W-1:0]  top_next;
  logic [PTR_W-1:0]  free_head_next;
  logic              top_we;
  link_wr_t          link_wr;
  logic              data_we;
  status_t           status_next;
  logic [DATA_W-1:0] pop_data_next;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign exec_go   = (state == S_EXEC) && (!res_valid || res_ready);

  // slot addressed by the incoming request
  assign sid_ok  = (32'(stack_id) < STACKS);
  assign sidx    = STK_W'(stack_id);
  assign top_in  = sid_ok ? stack_top[sidx] : NULL_PTR;
  assign slot_in = (kind == KIND_POP) ? top_in : free_head;

  // memories
  msb_link_store u_link (
    .clk   (clk),
    .rst   (rst),
    .wr    (link_wr),
    .re    (accept),
    .raddr (IDX_W'(slot_in)),
    .rdata (link_q)
  );

  msb_ram #(
    .W     (DATA_W),
    .DEPTH (SLOTS)
  ) u_data (
    .clk   (clk),
    .we    (data_we),
    .waddr (IDX_W'(r_slot)),
    .wdata (r_value),
    .re    (accept),
    .raddr (IDX_W'(slot_in)),
    .rdata (data_q)
  );

  assign top_cur = r_sid_ok ? stack_top[r_sidx] : NULL_PTR;

  // list update for push and pop
  always_comb begin
    free_head_next = free_head;
    top_next       = top_cur;
    top_we         = 1'b0;
    link_wr.we     = 1'b0;
    link_wr.idx    = IDX_W'(r_slot);
    link_wr.ptr    = top_cur;
    data_we        = 1'b0;
    status_next    = ST_OK;
    pop_data_next  = '0;
    if (r_kind == KIND_PUSH) begin
      if (is_null(free_head)) begin
        status_next = ST_OVERFLOW;
      end else if (r_sid_ok) begin
        free_head_next = link_q;
        top_next       = r_slot;
        top_we         = exec_go;
        link_wr.we     = exec_go;
        link_wr.ptr    = top_cur;
        data_we        = exec_go;
      end
    end else begin
      if (!r_sid_ok || is_null(r_slot)) begin
        status_next   = ST_UNDERFLOW;
        pop_data_next = UNDERFLOW_WORD;
      end else begin
        top_next       = link_q;
        top_we         = exec_go;
        link_wr.we     = exec_go;
        link_wr.ptr    = free_head;
        free_head_next = r_slot;
        pop_data_next  = data_q;
      end
    end
  end

  // sequencer, list heads and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      free_head <= '0;
      for (int i = 0; i < STACKS; i++) begin
        stack_top[i] <= NULL_PTR;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_EXEC;
            r_kind   <= kind;
            r_sid_ok <= sid_ok;
            r_sidx   <= sidx;
            r_value  <= value;
            r_slot   <= slot_in;
          end
          if (res_valid && res_ready) begin
            res_valid <= 1'b0;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state       <= S_IDLE;
            free_head   <= free_head_next;
            if (top_we) begin
              stack_top[r_sidx] <= top_next;
            end
            res_valid   <= 1'b1;
            pop_data    <= pop_data_next;
            status      <= status_next;
            store_full  <= is_null(free_head_next);
            stack_empty <= !r_sid_ok || is_null(top_next);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/msb_checker.sv @@
// port-level checks on the multi-stack shared buffer, bound to the top level
`timescale 1ns / 1ps
module msb_port_checker
  import msb_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              kind,
  input logic [SID_W-1:0]  stack_id,
  input logic [DATA_W-1:0] value,
  input logic              res_valid,
  input logic              res_ready,
  input logic [DATA_W-1:0] pop_data,
  input logic [1:0]        status,
  input logic              store_full,
  input logic              stack_empty
);

  // a stalled result holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(pop_data) && $stable(status))
    else $error("result changed while stalled");

  // underflow gives the fixed word and an empty stack
  a_underflow: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ST_UNDERFLOW) |-> (pop_data == UNDERFLOW_WORD) && stack_empty)
    else $error("underflow result inconsistent");

  // overflow only with the store still full and a zero data word
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ST_OVERFLOW) |-> store_full && (pop_data == '0))
    else $error("overflow result inconsistent");

  // a request occupies the update cycle after it is taken
  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken during update cycle");

endmodule

bind multi_stack_shared_buffer_unit msb_port_checker u_msb_checker (.*);

@@ tb/msb_checker.sv @@
// request/result monitor, free-list stack predictor and result comparison
`timescale 1ns / 1ps
module msb_checker
  import msb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_ready,
  input  logic              kind,
  input  logic [SID_W-1:0]  stack_id,
  input  logic [DATA_W-1:0] value,
  input  logic              res_valid,
  input  logic              res_ready,
  input  logic [DATA_W-1:0] pop_data,
  input  logic [1:0]        status,
  input  logic              store_full,
  input  logic              stack_empty,
  output int                fail_count,
  output int                open_count
);

  // one predicted result
  typedef struct {
    logic [DATA_W-1:0] pop_data;
    status_t           status;
    logic              full;
    logic              empty;
  } msb_result_t;

  // shadow copy of the slot store, links, stack heads and free list
  logic [DATA_W-1:0] slot_word [SLOTS];
  logic [PTR_W-1:0]  slot_link [SLOTS];
  logic [PTR_W-1:0]  stack_head [STACKS];
  logic [PTR_W-1:0]  free_head_ptr;

  msb_result_t expected_results [$];
  msb_result_t want;
  int          errors = 0;
  int          i;

  assign fail_count = errors;

  // walk one request through the free-list model, return its result
  function automatic msb_result_t apply_request(input logic k,
                                                input logic [SID_W-1:0] sid,
                                                input logic [DATA_W-1:0] v);
    msb_result_t      r;
    logic [PTR_W-1:0] slot;
    logic             sid_ok;
    r.pop_data = '0;
    r.status   = ST_OK;
    sid_ok     = int'(sid) < STACKS;
    if (k == KIND_PUSH) begin
      if (free_head_ptr >= NULL_PTR) begin
        r.status = ST_OVERFLOW;
      end else if (sid_ok) begin
        slot                        = free_head_ptr;
        free_head_ptr               = slot_link[slot[IDX_W-1:0]];
        slot_link[slot[IDX_W-1:0]]  = stack_head[sid];
        stack_head[sid]             = slot;
        slot_word[slot[IDX_W-1:0]]  = v;
      end
    end else begin
      if (!sid_ok || stack_head[sid] >= NULL_PTR) begin
        r.status   = ST_UNDERFLOW;
        r.pop_data = UNDERFLOW_WORD;
      end else begin
        slot                        = stack_head[sid];
        stack_head[sid]             = slot_link[slot[IDX_W-1:0]];
        slot_link[slot[IDX_W-1:0]]  = free_head_ptr;
        free_head_ptr               = slot;
        r.pop_data                  = slot_word[slot[IDX_W-1:0]];
      end
    end
    r.full  = free_head_ptr >= NULL_PTR;
    r.empty = !sid_ok || stack_head[sid] >= NULL_PTR;
    return r;
  endfunction

  // flag one field that differs from the prediction
  task automatic report_field(input string name, input logic [DATA_W-1:0] exp_val,
                              input logic [DATA_W-1:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  // watch both channels
  always @(posedge clk) begin
    if (rst) begin
      for (i = 0; i < SLOTS; i++) begin
        slot_word[i] = '0;
        slot_link[i] = PTR_W'(i + 1);
      end
      slot_link[SLOTS-1] = NULL_PTR;
      for (i = 0; i < STACKS; i++) stack_head[i] = NULL_PTR;
      free_head_ptr = '0;
      expected_results.delete();
    end else begin
      // result side: compare with the oldest prediction
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending, pop_data %h status %0d",
                   $time, pop_data, status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          report_field("pop_data", want.pop_data, pop_data);
          report_field("status", DATA_W'(want.status), DATA_W'(status));
          report_field("store_full", DATA_W'(want.full), DATA_W'(store_full));
          report_field("stack_empty", DATA_W'(want.empty), DATA_W'(stack_empty));
        end
      end
      // request side: predict
      if (req_valid && req_ready)
        expected_results.push_back(apply_request(kind, stack_id, value));
    end
    open_count <= expected_results.size();
  end

  // predictions never matched by a result
  final begin
    if (expected_results.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
  end

endmodule

@@ tb/tb_top.sv @@
// testbench top: clock, reset, request stimulus, result back-pressure and verdict
`timescale 1ns / 1ps
module tb_top;
  import msb_pkg::*;

  localparam int RANDOM_REQS = 2000;
  localparam int TAIL_REQS   = 200;
  localparam int CYCLE_LIMIT = 500000;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  logic              kind;
  logic [SID_W-1:0]  stack_id;
  logic [DATA_W-1:0] value;
  logic              res_valid;
  logic              res_ready;
  logic [DATA_W-1:0] pop_data;
  logic [1:0]        status;
  logic              store_full;
  logic              stack_empty;
  logic              tail_phase;
  int                fail_count;
  int                open_count;
  int                cycles = 0;

  multi_stack_shared_buffer_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .kind        (kind),
    .stack_id    (stack_id),
    .value       (value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .pop_data    (pop_data),
    .status      (status),
    .store_full  (store_full),
    .stack_empty (stack_empty)
  );

  msb_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .kind        (kind),
    .stack_id    (stack_id),
    .value       (value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .pop_data    (pop_data),
    .status      (status),
    .store_full  (store_full),
    .stack_empty (stack_empty),
    .fail_count  (fail_count),
    .open_count  (open_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // hold one request until it is taken
  task automatic send_request(input logic k, input logic [SID_W-1:0] sid,
                              input logic [DATA_W-1:0] v);
    req_valid <= 1'b1;
    kind      <= k;
    stack_id  <= sid;
    value     <= v;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // data word: mostly random, sometimes a corner value
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // result back-pressure in bursts, none in the tail
  initial begin
    res_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!tail_phase && $urandom_range(0, 3) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      res_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // request stimulus
  initial begin
    int          push_pct;
    int          focus_sid;
    bit          focus_on;
    bit          idle_on;
    logic        k;
    logic [SID_W-1:0] sid;
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    kind       <= KIND_PUSH;
    stack_id   <= '0;
    value      <= '0;
    tail_phase <= 1'b0;
    push_pct   = 50;
    focus_sid  = 0;
    focus_on   = 0;
    idle_on    = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // underflow on every empty stack
    for (int s = 0; s < STACKS; s++) send_request(KIND_POP, SID_W'(s), pick_value());
    // fill the whole store, corner words first and then random words, spread over all stacks
    send_request(KIND_PUSH, 2'd0, 32'h8000_0000);
    send_request(KIND_PUSH, 2'd1, 32'h7fff_ffff);
    send_request(KIND_PUSH, 2'd2, 32'h0000_0000);
    send_request(KIND_PUSH, 2'd3, 32'hffff_ffff);
    send_request(KIND_PUSH, 2'd0, 32'haaaa_aaaa);
    send_request(KIND_PUSH, 2'd1, 32'h5555_5555);
    send_request(KIND_PUSH, 2'd2, 32'h0000_0001);
    for (int n = 7; n < SLOTS; n++) send_request(KIND_PUSH, SID_W'(n), $urandom);
    // push with no free slot
    send_request(KIND_PUSH, 2'd2, 32'h1234_5678);
    // pop one from each stack, store no longer full
    for (int s = STACKS - 1; s >= 0; s--) send_request(KIND_POP, SID_W'(s), '0);

    // random segments with their own push bias, stack focus and idling
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 80 == 0) begin
        case ($urandom_range(0, 3))
          0:       push_pct = 20;
          1:       push_pct = 50;
          2:       push_pct = 80;
          default: push_pct = 95;
        endcase
        focus_on  = $urandom_range(0, 1);
        focus_sid = $urandom_range(0, STACKS - 1);
        idle_on   = $urandom_range(0, 2) != 0;
      end
      if (n == RANDOM_REQS - TAIL_REQS) begin
        tail_phase <= 1'b1;
        idle_on    = 0;
      end
      k   = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
      sid = (focus_on && $urandom_range(0, 9) < 7) ? SID_W'(focus_sid)
                                                   : SID_W'($urandom_range(0, 3));
      send_request(k, sid, pick_value());
      // sender gap
      if (idle_on && $urandom_range(0, 3) == 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
    req_valid <= 1'b0;

    // drain, then let the pipeline settle
    while (open_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
